@@ hw/rtl/tac_pkg.sv @@
// ----------------------------------------------------------------------------
// tac_pkg: shared types and constants for the thermistor converter
// Formats of the log pipeline, the divider and the register map.
// ----------------------------------------------------------------------------
package tac_pkg;

    localparam int LOG_FRAC = 24;
    localparam int LOG_EW   = 5;
    localparam int LOG_W    = LOG_EW + LOG_FRAC;

    localparam logic signed [32:0] LN2_Q32    = 33'sd2977044472;
    localparam logic signed [58:0] KELVIN_Q16 = 59'sd17901158;
    localparam logic signed [58:0] ROUND_HALF = 59'sd128;

    localparam int DIV_QW = 57;
    localparam int DIV_DW = 41;

    localparam logic [1:0] REG_COEFF_A = 2'd0;
    localparam logic [1:0] REG_COEFF_B = 2'd1;
    localparam logic [1:0] REG_COEFF_C = 2'd2;
    localparam logic [1:0] REG_SERIES  = 2'd3;

    localparam logic signed [15:0] TEMP_MAX = 16'sh7FFF;
    localparam logic signed [15:0] TEMP_MIN = -16'sh8000;

    typedef struct packed {
        logic       valid;
        logic [1:0] channel;
        logic       fault;
    } side_t;

    typedef struct packed {
        logic signed [31:0] coeff_a;
        logic signed [31:0] coeff_b;
        logic signed [31:0] coeff_c;
        logic [19:0]        series_resistance;
    } cfg_t;

endpackage

@@ hw/rtl/tac_if.sv @@
// ----------------------------------------------------------------------------
// tac_if: request channels of the thermistor converter
// Sample channel in, result channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface tac_sample_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel;
    logic [11:0] adc_sample;

    modport source (output valid, output channel, output adc_sample, input ready);
    modport sink (input valid, input channel, input adc_sample, output ready);
endinterface

interface tac_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         channel_out;
    logic signed [15:0] temperature;
    logic               fault;

    modport source (output valid, output channel_out, output temperature,
                    output fault, input ready);
    modport sink (input valid, input channel_out, input temperature,
                  input fault, output ready);
endinterface

@@ hw/rtl/tac_cfg.sv @@
// ----------------------------------------------------------------------------
// tac_cfg: configuration registers
// APB-style write and read of the Steinhart-Hart coefficients and resistor.
// ----------------------------------------------------------------------------
module tac_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tac_pkg::cfg_t      cfg
);

    tac_pkg::cfg_t cfg_reg;
    logic [1:0]    index;
    logic          wr;

    assign pready = 1'b1;
    assign index  = paddr[3:2];
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coeff_a           <= 32'sd1236000000;
            cfg_reg.coeff_b           <= 32'sd257000000;
            cfg_reg.coeff_c           <= 32'sd25000000;
            cfg_reg.series_resistance <= 20'd10000;
        end
        else if (wr)
        begin
            case (index)
                tac_pkg::REG_COEFF_A: cfg_reg.coeff_a <= $signed(pwdata);
                tac_pkg::REG_COEFF_B: cfg_reg.coeff_b <= $signed(pwdata);
                tac_pkg::REG_COEFF_C: cfg_reg.coeff_c <= $signed(pwdata);
                tac_pkg::REG_SERIES:  cfg_reg.series_resistance <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            tac_pkg::REG_COEFF_A: prdata = cfg_reg.coeff_a;
            tac_pkg::REG_COEFF_B: prdata = cfg_reg.coeff_b;
            tac_pkg::REG_COEFF_C: prdata = cfg_reg.coeff_c;
            tac_pkg::REG_SERIES:  prdata = {12'd0, cfg_reg.series_resistance};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

@@ hw/rtl/tac_log2.sv @@
// ----------------------------------------------------------------------------
// tac_log2: pipelined binary logarithm
// Leading-one search, normalise, then one squaring stage per fraction bit.
// ----------------------------------------------------------------------------
module tac_log2
#(
    parameter int XW = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [XW-1:0]                x,
    input  tac_pkg::side_t               side_in,
    output logic [tac_pkg::LOG_W-1:0]    log_out,
    output tac_pkg::side_t               side_out
);

    localparam int NF = tac_pkg::LOG_FRAC;
    localparam int EW = tac_pkg::LOG_EW;

    logic [XW-1:0]   x0_reg;
    tac_pkg::side_t  s0_reg;
    logic [XW-1:0]   x1_reg;
    logic [EW-1:0]   e1_reg;
    logic [EW-1:0]   e1_next;
    tac_pkg::side_t  s1_reg;

    logic [30:0]     m_reg [0:NF];
    logic [30:0]     m_next [0:NF];
    logic [EW-1:0]   e_reg [0:NF];
    logic [NF-1:0]   f_reg [0:NF];
    logic [NF-1:0]   f_next [0:NF];
    tac_pkg::side_t  side_reg [0:NF];
    logic [61:0]     sq [1:NF];

    // find the leading one
    always_comb
    begin
        e1_next = '0;
        for (int i = 0; i < XW; i++)
        begin
            if (x0_reg[i])
            begin
                e1_next = EW'(i);
            end
        end
    end

    always_comb
    begin
        m_next[0] = 31'(x1_reg) << (EW'(30) - e1_reg);
        f_next[0] = '0;
        for (int k = 1; k <= NF; k++)
        begin
            sq[k] = 62'(m_reg[k-1]) * 62'(m_reg[k-1]);
            if (sq[k][61])
            begin
                m_next[k] = sq[k][61:31];
            end
            else
            begin
                m_next[k] = sq[k][60:30];
            end
            f_next[k] = {f_reg[k-1][NF-2:0], sq[k][61]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
            for (int k = 0; k <= NF; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            s0_reg      <= side_in;
            s1_reg      <= s0_reg;
            side_reg[0] <= s1_reg;
            for (int k = 1; k <= NF; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg   <= x;
            x1_reg   <= x0_reg;
            e1_reg   <= e1_next;
            m_reg[0] <= m_next[0];
            e_reg[0] <= e1_reg;
            f_reg[0] <= f_next[0];
            for (int k = 1; k <= NF; k++)
            begin
                m_reg[k] <= m_next[k];
                e_reg[k] <= e_reg[k-1];
                f_reg[k] <= f_next[k];
            end
        end
    end

    assign log_out  = {e_reg[NF], f_reg[NF]};
    assign side_out = side_reg[NF];

endmodule

@@ hw/rtl/tac_div.sv @@
// ----------------------------------------------------------------------------
// tac_div: pipelined restoring divider
// Forms 2^56 / divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tac_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [tac_pkg::DIV_DW-1:0]    divisor,
    input  tac_pkg::side_t                side_in,
    output logic [tac_pkg::DIV_QW-1:0]    quotient,
    output tac_pkg::side_t                side_out
);

    localparam int QW = tac_pkg::DIV_QW;
    localparam int DW = tac_pkg::DIV_DW;

    logic [DW-1:0]   d_reg [0:QW-1];
    logic [DW-1:0]   r_reg [0:QW-1];
    logic [DW-1:0]   r_next [0:QW-1];
    logic [QW-1:0]   q_reg [0:QW-1];
    logic [QW-1:0]   q_next [0:QW-1];
    logic [DW:0]     trial [0:QW-1];
    logic [DW-1:0]   d_in [0:QW-1];
    tac_pkg::side_t  side_reg [0:QW-1];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            // the dividend has a single one at its top bit
            if (k == 0)
            begin
                trial[k]  = {{DW{1'b0}}, 1'b1};
                d_in[k]   = divisor;
                q_next[k] = '0;
            end
            else
            begin
                trial[k]  = {r_reg[k-1], 1'b0};
                d_in[k]   = d_reg[k-1];
                q_next[k] = {q_reg[k-1][QW-2:0], 1'b0};
            end
            if (trial[k] >= {1'b0, d_in[k]})
            begin
                r_next[k]    = DW'(trial[k] - {1'b0, d_in[k]});
                q_next[k][0] = 1'b1;
            end
            else
            begin
                r_next[k] = trial[k][DW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < QW; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                d_reg[k] <= d_in[k];
                r_reg[k] <= r_next[k];
                q_reg[k] <= q_next[k];
            end
        end
    end

    assign quotient = q_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

@@ hw/rtl/thermistor_adc_to_celsius.sv @@
// ----------------------------------------------------------------------------
// thermistor_adc_to_celsius: divider ADC sample to degrees Celsius
// Steinhart-Hart conversion of tagged thermistor samples, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   sample: one request carries a channel tag and a raw divider reading.
//   result: channel tag, temperature in signed Q8.8 Celsius and a fault flag.
//   Registers (APB, byte address 4*i): coeff_a, coeff_b, coeff_c,
//   series_resistance; write them while no request is in flight.
// Throughput: one request per cycle while the receiver does not stall.
// Pipeline: from acceptance to result valid, 27 stages of log pipeline
//   (one squaring multiplier per fraction bit), six polynomial stages,
//   57 divider stages (one quotient bit each) and the output register.
// Reset clears every valid bit and loads the register defaults.
// When the receiver stalls, the whole pipeline holds; a sample is still
//   taken whenever the output register is empty or being drained.
// A sample at zero or full scale, a zero resistor or a non-positive 1/T
//   gives fault with temperature zero; out-of-range values saturate.
// ----------------------------------------------------------------------------
module thermistor_adc_to_celsius
#(
    parameter int ADC_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    tac_sample_if.sink          sample,
    tac_result_if.source        result
);

    localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};
    localparam int LW = tac_pkg::LOG_W;

    tac_pkg::cfg_t   cfg;
    logic            adv;
    logic [ADC_BITS-1:0] adc;
    logic [ADC_BITS-1:0] adc_rest;
    tac_pkg::side_t  side_in;
    tac_pkg::side_t  side_log;
    logic [LW-1:0]   log_rs;
    logic [LW-1:0]   log_adc;
    logic [LW-1:0]   log_rest;

    logic signed [31:0]  lsum_reg;
    tac_pkg::side_t      p1_reg;
    logic signed [64:0]  prod_ln;
    logic signed [31:0]  l2s_reg;
    tac_pkg::side_t      p2_reg;
    logic signed [63:0]  prod_sq;
    logic signed [63:0]  prod_b;
    logic signed [39:0]  sq3_reg;
    logic signed [31:0]  l3s_reg;
    logic signed [39:0]  bl3_reg;
    tac_pkg::side_t      p3_reg;
    logic signed [71:0]  prod_cube;
    logic signed [31:0]  cube4_reg;
    logic signed [39:0]  bl4_reg;
    tac_pkg::side_t      p4_reg;
    logic signed [63:0]  prod_c;
    logic signed [39:0]  cl5_reg;
    logic signed [39:0]  bl5_reg;
    tac_pkg::side_t      p5_reg;
    logic signed [41:0]  s_next;
    logic signed [41:0]  s_reg;
    tac_pkg::side_t      p6_reg;
    tac_pkg::side_t      p6_next;

    logic [tac_pkg::DIV_QW-1:0] kq16;
    tac_pkg::side_t      side_div;
    logic signed [58:0]  cel_full;
    logic signed [50:0]  cel;
    logic signed [15:0]  temp_next;

    logic                res_valid_reg;
    logic [1:0]          res_channel_reg;
    logic signed [15:0]  res_temp_reg;
    logic                res_fault_reg;

    tac_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // advance the whole pipeline unless the output register is held
    assign adv          = !res_valid_reg || result.ready;
    assign sample.ready = adv;

    assign adc      = ADC_BITS'(sample.adc_sample);
    assign adc_rest = FULL_SCALE - adc;

    assign side_in.valid   = sample.valid;
    assign side_in.channel = sample.channel;
    assign side_in.fault   = (adc == '0) || (adc == FULL_SCALE)
                          || (cfg.series_resistance == 20'd0);

    tac_log2 #(.XW(20)) u_log_rs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .x        (cfg.series_resistance),
        .side_in  (side_in),
        .log_out  (log_rs),
        .side_out ()
    );

    tac_log2 #(.XW(ADC_BITS)) u_log_adc
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .x        (adc),
        .side_in  (side_in),
        .log_out  (log_adc),
        .side_out (side_log)
    );

    tac_log2 #(.XW(ADC_BITS)) u_log_rest
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .x        (adc_rest),
        .side_in  (side_in),
        .log_out  (log_rest),
        .side_out ()
    );

    assign prod_ln   = lsum_reg * tac_pkg::LN2_Q32;
    assign prod_sq   = l2s_reg * l2s_reg;
    assign prod_b    = cfg.coeff_b * l2s_reg;
    assign prod_cube = sq3_reg * l3s_reg;
    assign prod_c    = cfg.coeff_c * cube4_reg;
    assign s_next    = 42'(cfg.coeff_a) + 42'(bl5_reg) + 42'(cl5_reg);

    always_comb
    begin
        p6_next       = p5_reg;
        p6_next.fault = p5_reg.fault || (s_next <= 42'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
            p3_reg <= '0;
            p4_reg <= '0;
            p5_reg <= '0;
            p6_reg <= '0;
        end
        else if (adv)
        begin
            p1_reg <= side_log;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            p4_reg <= p3_reg;
            p5_reg <= p4_reg;
            p6_reg <= p6_next;
        end
    end

    // floor shifts are plain bit selects of the signed products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lsum_reg  <= $signed(32'(log_rs) + 32'(log_adc) - 32'(log_rest));
            l2s_reg   <= prod_ln[63:32];
            sq3_reg   <= prod_sq[63:24];
            l3s_reg   <= l2s_reg;
            bl3_reg   <= prod_b[63:24];
            cube4_reg <= prod_cube[63:32];
            bl4_reg   <= bl3_reg;
            cl5_reg   <= prod_c[63:24];
            bl5_reg   <= bl4_reg;
            s_reg     <= s_next;
        end
    end

    tac_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .divisor  (s_reg[tac_pkg::DIV_DW-1:0]),
        .side_in  (p6_reg),
        .quotient (kq16),
        .side_out (side_div)
    );

    assign cel_full = $signed({2'b00, kq16}) - tac_pkg::KELVIN_Q16 + tac_pkg::ROUND_HALF;
    assign cel      = cel_full[58:8];

    always_comb
    begin
        if (side_div.fault)
        begin
            temp_next = 16'sd0;
        end
        else if (cel > 51'(tac_pkg::TEMP_MAX))
        begin
            temp_next = tac_pkg::TEMP_MAX;
        end
        else if (cel < 51'(tac_pkg::TEMP_MIN))
        begin
            temp_next = tac_pkg::TEMP_MIN;
        end
        else
        begin
            temp_next = cel[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= side_div.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_channel_reg <= side_div.channel;
            res_temp_reg    <= temp_next;
            res_fault_reg   <= side_div.fault;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.channel_out = res_channel_reg;
    assign result.temperature = res_temp_reg;
    assign result.fault       = res_fault_reg;

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.fault |-> result.temperature == 16'sd0)
        else $error("faulted result carries a temperature");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready == (!result.valid || result.ready))
        else $error("sample ready out of step with the output register");

    a_s_positive: assert property (@(posedge clk) disable iff (!rst_n)
        p6_reg.valid && !p6_reg.fault |-> s_reg > 42'sd0)
        else $error("non-positive reciprocal passed to divider without fault");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(p6_reg) && $stable(s_reg))
        else $error("pipeline moved during a stall");

endmodule

@@ verif/tb_thermistor_adc_to_celsius.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_thermistor_adc_to_celsius: self-checking bench for the converter
// Drives tagged samples under varied flow control and register settings,
// predicts each Celsius result in fixed point and checks it in order.
// ----------------------------------------------------------------------------
module tb_thermistor_adc_to_celsius;

    typedef struct packed {
        logic [1:0]  channel;
        logic [11:0] adc;
    } sample_t;

    typedef struct packed {
        logic [1:0]         channel;
        logic signed [15:0] temperature;
        logic               fault;
    } celsius_t;

    localparam int  ADC_FS   = 4095;
    localparam int  DRAIN_CY = 120;
    localparam int  HOLD_CY  = 400;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tac_sample_if sample_ch ();
    tac_result_if result_ch ();

    thermistor_adc_to_celsius u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch.sink),
        .result  (result_ch.source)
    );

    // local copy of the register file
    logic signed [31:0] cur_a;
    logic signed [31:0] cur_b;
    logic signed [31:0] cur_c;
    logic [19:0]        cur_series;

    sample_t  pending_samples[$];
    celsius_t expected_celsius[$];

    int error_count = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int fault_count = 0;
    int sat_count = 0;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_seen;
    int hold_cycles;

    logic sample_taken;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint log2_q24(input logic [31:0] x);
        int          e;
        logic [63:0] m;
        longint      frac;
        e = 0;
        frac = 0;
        while (e < 31 && (x >> (e + 1)) != 0)
            e++;
        m = 64'(x) << (30 - e);
        for (int i = 0; i < tac_pkg::LOG_FRAC; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(e) << tac_pkg::LOG_FRAC) + frac;
    endfunction

    function automatic celsius_t convert_sample(input sample_t s);
        celsius_t    r;
        longint      lsum, lnr, lnr2, lnr3, inv_t, c;
        logic [63:0] kelvin;
        r.channel = s.channel;
        r.temperature = '0;
        r.fault = 1'b1;
        if (s.adc != 0 && s.adc != ADC_FS && cur_series != 0)
        begin
            lsum = log2_q24(32'(cur_series)) + log2_q24(32'(s.adc))
                 - log2_q24(32'(ADC_FS - s.adc));
            lnr  = (lsum * 64'sd2977044472) >>> 32;
            lnr2 = (lnr * lnr) >>> 24;
            lnr3 = (lnr2 * lnr) >>> 32;
            inv_t = longint'(cur_a) + ((longint'(cur_b) * lnr) >>> 24)
                  + ((longint'(cur_c) * lnr3) >>> 24);
            if (inv_t > 0)
            begin
                kelvin = (64'd1 << 56) / 64'(inv_t);
                c = (longint'(kelvin) - 64'sd17901158 + 128) >>> 8;
                if (c > 32767)
                    c = 32767;
                if (c < -32768)
                    c = -32768;
                r.temperature = 16'(c);
                r.fault = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("MISMATCH %s at result %0d: got %0d, want %0d", what, checked_count,
                 got, want);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            tac_pkg::REG_COEFF_A: cur_a = value;
            tac_pkg::REG_COEFF_B: cur_b = value;
            tac_pkg::REG_COEFF_C: cur_c = value;
            default:              cur_series = value[19:0];
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_coeffs(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] rs);
        apb_write(tac_pkg::REG_COEFF_A, a);
        apb_write(tac_pkg::REG_COEFF_B, b);
        apb_write(tac_pkg::REG_COEFF_C, c);
        apb_write(tac_pkg::REG_SERIES, rs);
    endtask

    // hold until every request is in and every result is out
    task automatic wait_drained();
        while (pending_samples.size() != 0 || sample_ch.valid || expected_celsius.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CY) @(posedge clk);
    endtask

    task automatic push_sample(input logic [1:0] ch, input logic [11:0] adc);
        sample_t s;
        s.channel = ch;
        s.adc = adc;
        pending_samples.push_back(s);
    endtask

    task automatic push_random(input int n);
        logic [11:0] adc;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0:       adc = 12'd0;
                1:       adc = 12'hFFF;
                2:       adc = 12'($urandom_range(1, 16));
                3:       adc = 12'($urandom_range(4079, 4094));
                default: adc = 12'($urandom_range(1, 4094));
            endcase
            push_sample(2'($urandom_range(0, 3)), adc);
        end
    endtask

    // driver: offer the next request after the previous one was taken
    always @(negedge clk)
    begin
        logic    taken;
        logic    nxt_valid;
        sample_t s;
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_ch.channel <= '0;
            sample_ch.adc_sample <= '0;
        end
        else
        begin
            taken = sample_ch.valid && sample_taken;
            nxt_valid = sample_ch.valid && !taken;
            if (!nxt_valid && pending_samples.size() != 0
                && $urandom_range(1, 100) > send_idle_pct)
            begin
                s = pending_samples.pop_front();
                sample_ch.channel <= s.channel;
                sample_ch.adc_sample <= s.adc;
                nxt_valid = 1'b1;
            end
            sample_ch.valid <= nxt_valid;
        end
    end

    // receiver flow control, with an optional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_cycles <= 0;
            hold_seen <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_cycles <= HOLD_CY;
            result_ch.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            result_ch.ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end

    always @(posedge clk or negedge rst_n)
    begin
        sample_t s;
        if (!rst_n)
            sample_taken <= 1'b0;
        else
        begin
            sample_taken <= sample_ch.valid && sample_ch.ready;
            if (sample_ch.valid && sample_ch.ready)
            begin
                s.channel = sample_ch.channel;
                s.adc = sample_ch.adc_sample;
                expected_celsius.push_back(convert_sample(s));
                accepted_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        celsius_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_celsius.size() == 0)
            begin
                report_mismatch("unexpected result, channel_out", result_ch.channel_out, -1);
            end
            else
            begin
                want = expected_celsius.pop_front();
                if (result_ch.channel_out !== want.channel)
                    report_mismatch("channel_out", result_ch.channel_out, want.channel);
                if (result_ch.temperature !== want.temperature)
                    report_mismatch("temperature", result_ch.temperature,
                                    want.temperature);
                if (result_ch.fault !== want.fault)
                    report_mismatch("fault", result_ch.fault, want.fault);
                if (want.fault)
                    fault_count++;
                else if (want.temperature == tac_pkg::TEMP_MAX
                         || want.temperature == tac_pkg::TEMP_MIN)
                    sat_count++;
                checked_count++;
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        cur_a = 32'sd1236000000;
        cur_b = 32'sd257000000;
        cur_c = 32'sd25000000;
        cur_series = 20'd10000;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, zero and full scale, under reset defaults
        push_sample(2'd0, 12'd0);
        push_sample(2'd1, 12'hFFF);
        push_sample(2'd2, 12'd1);
        push_sample(2'd3, 12'd4094);
        push_sample(2'd0, 12'd2048);
        push_sample(2'd1, 12'd2047);
        push_sample(2'd2, 12'hAAA);
        push_sample(2'd3, 12'h555);
        push_sample(2'd1, 12'd100);
        push_sample(2'd2, 12'd3900);
        wait_drained();

        // zero resistor, then smallest and widest resistor
        set_coeffs(32'sd1236000000, 32'sd257000000, 32'sd25000000, 32'd0);
        push_sample(2'd0, 12'd2000);
        push_sample(2'd3, 12'd1);
        wait_drained();
        apb_write(tac_pkg::REG_SERIES, 32'd1);
        push_sample(2'd1, 12'd1);
        push_sample(2'd2, 12'd4094);
        wait_drained();
        apb_write(tac_pkg::REG_SERIES, 32'hFFFFF);
        push_sample(2'd1, 12'd1);
        push_sample(2'd2, 12'd4094);
        wait_drained();

        // negative 1/T gives fault; tiny positive 1/T saturates high
        set_coeffs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd10000);
        push_sample(2'd0, 12'd2048);
        push_sample(2'd1, 12'd4094);
        wait_drained();
        set_coeffs(32'sd1, 32'sd0, 32'sd0, 32'd10000);
        push_sample(2'd2, 12'd1000);
        wait_drained();
        set_coeffs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1000000);
        push_sample(2'd3, 12'd3000);
        push_sample(2'd0, 12'd1);
        wait_drained();

        // random phases, one flow-control mode and register set each
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (ph == 0)
                set_coeffs(32'sd1236000000, 32'sd257000000, 32'sd25000000, 32'd10000);
            else if (ph == 4)
                set_coeffs(32'sd1100000000, 32'sd260000000, 32'sd30000000, 32'd1000000);
            else
                set_coeffs($urandom_range(0, 1) ? $urandom()
                               : 32'($urandom_range(800000000, 1400000000)),
                           $urandom_range(0, 1) ? $urandom()
                               : 32'($urandom_range(200000000, 300000000)),
                           $urandom(), 32'($urandom_range(1, 1000000)));
            push_random(135);
            // long hold-off while the sender keeps offering
            if (ph == 5)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                @(negedge clk);
                hold_req = hold_req + 1;
            end
            wait_drained();
        end

        $display("Checked %0d of %0d requests: %0d faults, %0d saturated values.",
                 checked_count, accepted_count, fault_count, sat_count);
        $display("Covered default, extreme and random coefficients under four flow modes.");
        if (error_count == 0 && expected_celsius.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
